>>> src/pls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

    // Default list capacity
    localparam int CAPACITY_DEF = 32;

    // Request codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_CHANGE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_POS   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Request beat
    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [7:0] item_value;
        logic [5:0]        slot_position;
    } req_t;

    // Response beat
    typedef struct packed {
        logic [1:0] status;
        logic [5:0] found_position;
        logic [5:0] entry_count;
    } rsp_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic ins;      // open a gap at the position and write the value
        logic del;      // close the gap at the position
        logic chg;      // overwrite the entry at the position
        logic capture;  // load the match flag from the compare
        logic shift;    // move match flags one cell toward the head
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> src/positional_list_store_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY signed bytes held in a row of cells, one
// entry per cell. Insert, delete and change are applied to all cells at
// once in the EXEC state, when the output register is free, and the
// response is loaded at the end of that cycle. A new request can be taken
// in that same cycle, so with a ready receiver these run back to back at
// one per cycle. Find loads a match flag in every cell, then walks the
// flags toward the head one cell per cycle, counting up to the list
// length: it passes through a compare state, a scan state that stops on
// a hit or at the list end, and a finish state that waits for the output
// register. The response sits in an output register, so a request is
// taken while the previous response waits; a new one is only finished
// once that register is free. The list is empty after reset.
module positional_list_store_top #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           req_valid,
    output logic          req_ready,
    input  pls_pkg::req_t req,
    output logic          rsp_valid,
    input  wire           rsp_ready,
    output pls_pkg::rsp_t rsp
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > 6) ? LW : 6) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    pls_pkg::req_t req_reg;
    pls_pkg::req_t req_next;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [LW-1:0] cnt_reg;
    logic [LW-1:0] cnt_next;
    logic [1:0]    fstat_reg;
    logic [1:0]    fstat_next;
    logic [5:0]    ffound_reg;
    logic [5:0]    ffound_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    pls_pkg::rsp_t rsp_reg;
    pls_pkg::rsp_t rsp_next;

    logic          accept;
    logic          out_free;
    logic          exec_go;
    logic          done_go;
    logic          rsp_write;
    logic [CW-1:0] len_ext;
    logic [CW-1:0] pos_ext;
    logic [CW-1:0] pos_norm;
    logic [CW-1:0] pos_idx;
    logic [CW-1:0] cnt_ext;
    logic [CW-1:0] hit_pos;
    logic [CW-1:0] cnt_out;
    logic [1:0]    ex_status;
    logic [LW-1:0] ex_len;
    logic          ex_ins;
    logic          ex_del;
    logic          ex_chg;
    logic          scan_miss;
    logic          scan_hit;
    pls_pkg::cell_ctl_t ctl;

    logic [7:0]    ent [CAPACITY];
    logic          mat [CAPACITY];

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign exec_go   = (state_reg == S_EXEC) && (req_reg.req_type != pls_pkg::OP_FIND)
                       && out_free;
    assign done_go   = (state_reg == S_DONE) && out_free;
    assign rsp_write = exec_go || done_go;
    assign req_ready = (state_reg == S_IDLE) || rsp_write;
    assign accept    = req_valid && req_ready;

    // Position normalization (zero acts as one for insert and delete)
    assign len_ext  = CW'(len_reg);
    assign pos_ext  = CW'(req_reg.slot_position);
    assign pos_norm = (req_reg.slot_position == 6'd0) ? CW'(1) : pos_ext;
    assign pos_idx  = pos_norm - CW'(1);

    // Request decode and range checks
    always_comb
    begin
        ex_status = pls_pkg::ST_OK;
        ex_len    = len_reg;
        ex_ins    = 1'b0;
        ex_del    = 1'b0;
        ex_chg    = 1'b0;
        unique case (req_reg.req_type)
            pls_pkg::OP_INSERT:
            begin
                if (pos_norm > len_ext + CW'(1))
                    ex_status = pls_pkg::ST_BAD_POS;
                else if (len_ext >= CW'(CAPACITY))
                    ex_status = pls_pkg::ST_FULL;
                else
                begin
                    ex_ins = 1'b1;
                    ex_len = len_reg + LW'(1);
                end
            end
            pls_pkg::OP_DELETE:
            begin
                if (pos_norm > len_ext)
                    ex_status = pls_pkg::ST_BAD_POS;
                else
                begin
                    ex_del = 1'b1;
                    ex_len = len_reg - LW'(1);
                end
            end
            pls_pkg::OP_CHANGE:
            begin
                if ((req_reg.slot_position == 6'd0) || (pos_ext > len_ext))
                    ex_status = pls_pkg::ST_BAD_POS;
                else
                    ex_chg = 1'b1;
            end
            pls_pkg::OP_FIND:
            begin
                ex_status = pls_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // Scan of the match flags: head cell holds the flag of position cnt + 1
    assign cnt_ext   = CW'(cnt_reg);
    assign hit_pos   = cnt_ext + CW'(1);
    assign scan_miss = (state_reg == S_SCAN) && (cnt_ext >= len_ext);
    assign scan_hit  = (state_reg == S_SCAN) && !scan_miss && mat[0];

    // Cell control broadcast
    always_comb
    begin
        ctl.ins     = exec_go && ex_ins;
        ctl.del     = exec_go && ex_del;
        ctl.chg     = exec_go && ex_chg;
        ctl.capture = (state_reg == S_EXEC) && (req_reg.req_type == pls_pkg::OP_FIND);
        ctl.shift   = (state_reg == S_SCAN) && !scan_miss && !scan_hit;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        fstat_next  = fstat_reg;
        ffound_next = ffound_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (req_reg.req_type == pls_pkg::OP_FIND)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
                else if (out_free)
                begin
                    len_next   = ex_len;
                    state_next = accept ? S_EXEC : S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_miss)
                begin
                    fstat_next  = pls_pkg::ST_NOT_FOUND;
                    ffound_next = 6'd0;
                    state_next  = S_DONE;
                end
                else if (scan_hit)
                begin
                    fstat_next  = pls_pkg::ST_OK;
                    ffound_next = hit_pos[5:0];
                    state_next  = S_DONE;
                end
                else
                    cnt_next = cnt_reg + LW'(1);
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = accept ? S_EXEC : S_IDLE;
            end
        endcase
        if (accept)
            req_next = req;
    end

    // Response register
    assign cnt_out = exec_go ? CW'(ex_len) : len_ext;

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_write)
        begin
            rsp_valid_next = 1'b1;
            rsp_next.entry_count = cnt_out[5:0];
            if (exec_go)
            begin
                rsp_next.status         = ex_status;
                rsp_next.found_position = 6'd0;
            end
            else
            begin
                rsp_next.status         = fstat_reg;
                rsp_next.found_position = ffound_reg;
            end
        end
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            len_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            len_reg       <= len_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        fstat_reg  <= fstat_next;
        ffound_reg <= ffound_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [7:0] left_e;
        logic [7:0] right_e;
        logic       right_m;

        if (i == 0)
        begin : g_head
            assign left_e = req_reg.item_value;
        end
        else
        begin : g_mid_l
            assign left_e = ent[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_e = ent[i];
            assign right_m = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_e = ent[i+1];
            assign right_m = mat[i+1];
        end

        pls_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .pos         (pos_idx),
            .val         (req_reg.item_value),
            .left_entry  (left_e),
            .right_entry (right_e),
            .right_match (right_m),
            .entry       (ent[i]),
            .match       (mat[i])
        );
    end

    // Checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_ext <= CW'(CAPACITY))
        else $error("list length beyond capacity");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_ext <= len_ext))
        else $error("scan ran past the list end");

    a_busy_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (state_reg != S_IDLE)) |=> rsp_valid_reg)
        else $error("request taken while busy without a response");

    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && ex_ins) |=> (len_reg == LW'($past(len_reg) + LW'(1))))
        else $error("insert did not grow the list");

endmodule

`default_nettype wire

>>> src/pls_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  wire               clk,
    input  pls_pkg::cell_ctl_t ctl,
    input  wire  [CW-1:0]     pos,          // zero-based target position
    input  wire  [7:0]        val,
    input  wire  [7:0]        left_entry,
    input  wire  [7:0]        right_entry,
    input  wire               right_match,
    output logic [7:0]        entry,
    output logic              match
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [7:0] entry_reg;
    logic [7:0] entry_next;
    logic       match_reg;
    logic       match_next;

    // Entry update: shift back on insert, forward on delete, write on hit
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (MY_IDX > pos)
                entry_next = left_entry;
            else if (MY_IDX == pos)
                entry_next = val;
        end
        else if (ctl.del)
        begin
            if (MY_IDX >= pos)
                entry_next = right_entry;
        end
        else if (ctl.chg)
        begin
            if (MY_IDX == pos)
                entry_next = val;
        end
    end

    // Match flag: load from compare, then ripple toward the head
    always_comb
    begin
        match_next = match_reg;
        if (ctl.capture)
            match_next = (entry_reg == val);
        else if (ctl.shift)
            match_next = right_match;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

`default_nettype wire
